// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PCRD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that implies a property in the same cycle.
`define PCRD_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// A condition that implies a property in the next cycle.
`define PCRD_ASSERT_NXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/pcrd_pkg.sv =====
// Package with the types and constants of the packet to command ring deframer.
`default_nettype none

package pcrd_pkg;

  // Packet header layout.
  localparam logic [31:0] FrameMagic = 32'hDEADBEEF;
  localparam int unsigned HdrBytes   = 7;
  localparam int unsigned MagicBytes = 4;
  localparam int unsigned LenPos     = 4;

  // Kind of input item.
  typedef enum logic {
    FUNC_PACKET = 1'b0,
    FUNC_READ   = 1'b1
  } func_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_NONE      = 3'd0,
    STAT_CMD_BYTE  = 3'd1,
    STAT_CMD_EMPTY = 3'd2,
    STAT_TAKEN     = 3'd3,
    STAT_COMMIT    = 3'd4,
    STAT_DROP      = 3'd5
  } status_e;

  // One result item.
  typedef struct packed {
    status_e    status;
    logic [7:0] cmd_byte;
    logic       cmd_last;
  } result_t;

  // Copy sequencer states.
  typedef enum logic {
    CP_IDLE = 1'b0,
    CP_COPY = 1'b1
  } cp_state_e;

endpackage

`default_nettype wire

// ===== rtl/pcrd_ring_mem.sv =====
// Byte ring storage with one write port and two registered read ports.
`default_nettype none

module pcrd_ring_mem #(
  parameter int unsigned RING_DEPTH = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [$clog2(RING_DEPTH)-1:0] waddr_i,
  input  wire logic [7:0]                    wdata_i,
  input  wire logic [$clog2(RING_DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(RING_DEPTH)-1:0] raddr_b_i,
  output logic      [7:0]                    rdata_a_o,
  output logic      [7:0]                    rdata_b_o
);

  logic [7:0] mem_q [RING_DEPTH];
  logic [7:0] rdata_a_q;
  logic [7:0] rdata_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem_q[raddr_a_i];
    rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ===== rtl/pcrd_body_copy.sv =====
// Packet body buffer and the sequencer that copies a body into the ring.
`default_nettype none
`include "assert_macros.svh"

module pcrd_body_copy #(
  parameter int unsigned RING_DEPTH = 128,
  parameter int unsigned PACKET_MAX = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Body byte write while a packet arrives.
  input  wire logic                          body_we_i,
  input  wire logic [((PACKET_MAX - pcrd_pkg::HdrBytes) > 1 ?
                      $clog2(PACKET_MAX - pcrd_pkg::HdrBytes) : 1)-1:0] body_idx_i,
  input  wire logic [7:0]                    body_data_i,
  // Copy request at commit.
  input  wire logic                          start_i,
  input  wire logic [7:0]                    start_len_i,
  input  wire logic [$clog2(RING_DEPTH)-1:0] start_addr_i,
  // Ring write and status.
  output logic                               busy_o,
  output logic                               ring_we_o,
  output logic      [$clog2(RING_DEPTH)-1:0] ring_addr_o,
  output logic      [7:0]                    ring_data_o
);

  localparam int unsigned BodyMax = PACKET_MAX - pcrd_pkg::HdrBytes;
  localparam int unsigned BW      = (BodyMax > 1) ? $clog2(BodyMax) : 1;
  localparam int unsigned AW      = $clog2(RING_DEPTH);

  logic [7:0]          body_mem [BodyMax];
  pcrd_pkg::cp_state_e state_q, state_d;
  logic [7:0]          cnt_q;
  logic [7:0]          len_q;
  logic [AW-1:0]       addr_q;
  logic                wr_pend_q;
  logic [AW-1:0]       wr_addr_q;
  logic [7:0]          wr_data_q;
  logic                rd_en;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Body buffer write port.
  always_ff @(posedge clk_i) begin
    if (body_we_i) begin
      body_mem[body_idx_i] <= body_data_i;
    end
  end

  // Body buffer read port and the registered ring write that follows it.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      wr_data_q <= body_mem[BW'(cnt_q)];
    end
    wr_addr_q <= addr_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcrd_pkg::CP_IDLE: begin
        if (start_i) begin
          state_d = pcrd_pkg::CP_COPY;
        end
      end
      pcrd_pkg::CP_COPY: begin
        if (cnt_q == len_q - 8'd1) begin
          state_d = pcrd_pkg::CP_IDLE;
        end
      end
      default: state_d = pcrd_pkg::CP_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    rd_en = 1'b0;
    unique case (state_q)
      pcrd_pkg::CP_IDLE: rd_en = 1'b0;
      pcrd_pkg::CP_COPY: rd_en = 1'b1;
      default:           rd_en = 1'b0;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pcrd_pkg::CP_IDLE;
      cnt_q     <= '0;
      len_q     <= '0;
      addr_q    <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= rd_en;
      if (start_i) begin
        cnt_q  <= '0;
        len_q  <= start_len_i;
        addr_q <= start_addr_i;
      end else if (rd_en) begin
        cnt_q  <= cnt_q + 8'd1;
        addr_q <= ring_inc(addr_q);
      end
    end
  end

  assign busy_o      = (state_q != pcrd_pkg::CP_IDLE) || wr_pend_q;
  assign ring_we_o   = wr_pend_q;
  assign ring_addr_o = wr_addr_q;
  assign ring_data_o = wr_data_q;

  `PCRD_ASSERT_IMP(a_start_when_idle, start_i, !busy_o, "copy started while busy")
  `PCRD_ASSERT_IMP(a_start_len, start_i, start_len_i != 8'd0, "copy started with no bytes")

endmodule

`default_nettype wire

// ===== rtl/pcrd_core.sv =====
// Item step logic and deframer state: header parse, commit and command pops.
`default_nettype none
`include "assert_macros.svh"

module pcrd_core #(
  parameter int unsigned RING_DEPTH = 128,
  parameter int unsigned PACKET_MAX = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic                          enable_i,
  input  wire logic                          func_i,
  input  wire logic [7:0]                    packet_byte_i,
  input  wire logic                          packet_last_i,
  // Ring bytes at the read pointer and the one after it.
  input  wire logic [7:0]                    rd_a_i,
  input  wire logic [7:0]                    rd_b_i,
  output logic      [$clog2(RING_DEPTH)-1:0] rd_addr_a_o,
  output logic      [$clog2(RING_DEPTH)-1:0] rd_addr_b_o,
  // Early ring write of a body byte into free space.
  output logic                               spec_we_o,
  output logic      [$clog2(RING_DEPTH)-1:0] spec_addr_o,
  // Body buffer write.
  output logic                               body_we_o,
  output logic      [((PACKET_MAX - pcrd_pkg::HdrBytes) > 1 ?
                      $clog2(PACKET_MAX - pcrd_pkg::HdrBytes) : 1)-1:0] body_idx_o,
  // Copy request for a body that could not be placed early.
  output logic                               copy_start_o,
  output logic      [7:0]                    copy_len_o,
  output logic      [$clog2(RING_DEPTH)-1:0] copy_addr_o,
  output pcrd_pkg::result_t                  result_o
);

  localparam int unsigned BodyMax = PACKET_MAX - pcrd_pkg::HdrBytes;
  localparam int unsigned BW      = (BodyMax > 1) ? $clog2(BodyMax) : 1;
  localparam int unsigned AW      = $clog2(RING_DEPTH);
  localparam int unsigned VW      = $clog2(RING_DEPTH + 1);
  localparam int unsigned PW      = $clog2(PACKET_MAX + 1);
  localparam int unsigned CW0     = (VW > PW) ? VW : PW;
  localparam int unsigned CW      = ((CW0 > 9) ? CW0 : 9) + 1;

  logic [AW-1:0] rp_q, rp_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [VW-1:0] avail_q, avail_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [31:0]   hdr_q, hdr_d;
  logic [7:0]    len_q, len_d;
  logic          rej_q, rej_d;
  logic [7:0]    crem_q, crem_d;
  logic          defer_q, defer_d;

  logic [CW-1:0] pos_c;
  logic [CW-1:0] k_c;
  logic [CW-1:0] free_c;
  logic [CW-1:0] spec_sum;
  logic [CW-1:0] commit_sum;
  logic [CW-1:0] chk_sum;
  logic          pos_full;
  logic          in_body;
  logic          fits;
  logic          defer_now;
  logic          commit_ok;
  logic [AW-1:0] rp_inc1;
  logic [AW-1:0] rp_inc2;
  logic [AW-1:0] commit_wp;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Packet position, body offset and room in the ring.
  assign pos_c    = CW'(pos_q);
  assign k_c      = pos_c - CW'(pcrd_pkg::HdrBytes);
  assign free_c   = CW'(RING_DEPTH) - CW'(avail_q);
  assign pos_full = pos_c >= CW'(PACKET_MAX);
  assign in_body  = (pos_c >= CW'(pcrd_pkg::HdrBytes)) && (k_c < CW'(BodyMax));
  assign fits     = k_c < free_c;
  assign defer_now = in_body && !fits && (k_c < CW'(len_q));

  // Ring address of a body byte placed ahead of the write pointer.
  assign spec_sum    = CW'(wp_q) + k_c;
  assign spec_addr_o = (spec_sum >= CW'(RING_DEPTH)) ? AW'(spec_sum - CW'(RING_DEPTH))
                                                     : AW'(spec_sum);
  assign body_idx_o  = BW'(k_c);

  // Commit test for the packet's last byte; a body length is only known
  // once the header is complete, which the total length check guarantees.
  assign commit_ok = enable_i && !rej_q && !pos_full && (hdr_q == pcrd_pkg::FrameMagic) &&
                     (pos_c + CW'(1) >= CW'(len_q) + CW'(pcrd_pkg::HdrBytes)) &&
                     (CW'(len_q) <= free_c) && (CW'(len_q) <= CW'(BodyMax));
  assign commit_sum = CW'(wp_q) + CW'(len_q);
  assign commit_wp  = (commit_sum >= CW'(RING_DEPTH)) ? AW'(commit_sum - CW'(RING_DEPTH))
                                                      : AW'(commit_sum);

  assign rp_inc1 = ring_inc(rp_q);
  assign rp_inc2 = ring_inc(rp_inc1);

  assign copy_len_o  = len_q;
  assign copy_addr_o = wp_q;

  // Step of one item.
  always_comb begin
    rp_d         = rp_q;
    wp_d         = wp_q;
    avail_d      = avail_q;
    pos_d        = pos_q;
    hdr_d        = hdr_q;
    len_d        = len_q;
    rej_d        = rej_q;
    crem_d       = crem_q;
    defer_d      = defer_q;
    spec_we_o    = 1'b0;
    body_we_o    = 1'b0;
    copy_start_o = 1'b0;
    result_o     = '{status: pcrd_pkg::STAT_NONE, cmd_byte: 8'd0, cmd_last: 1'b0};
    if (step_i) begin
      if (func_i == pcrd_pkg::FUNC_PACKET) begin
        // Header capture and body store.
        if (!enable_i || pos_full) begin
          rej_d = 1'b1;
        end else begin
          if (pos_c < CW'(pcrd_pkg::MagicBytes)) begin
            hdr_d = {packet_byte_i, hdr_q[31:8]};
          end else if (pos_c == CW'(pcrd_pkg::LenPos)) begin
            len_d = packet_byte_i;
          end else if (in_body) begin
            body_we_o = 1'b1;
            spec_we_o = fits;
            defer_d   = defer_q | defer_now;
          end
          pos_d = pos_q + PW'(1);
        end
        // Commit or drop at the end of the packet.
        if (packet_last_i) begin
          if (commit_ok) begin
            wp_d         = commit_wp;
            avail_d      = avail_q + VW'(len_q);
            copy_start_o = defer_q | defer_now;
            result_o.status = pcrd_pkg::STAT_COMMIT;
          end else begin
            result_o.status = pcrd_pkg::STAT_DROP;
          end
          pos_d   = '0;
          hdr_d   = '0;
          len_d   = '0;
          rej_d   = 1'b0;
          defer_d = 1'b0;
        end else begin
          result_o.status = pcrd_pkg::STAT_TAKEN;
        end
      end else if (enable_i && (avail_q != '0)) begin
        // Command pop.
        if (crem_q != 8'd0) begin
          rp_d    = rp_inc1;
          avail_d = avail_q - VW'(1);
          crem_d  = crem_q - 8'd1;
          result_o.status   = pcrd_pkg::STAT_CMD_BYTE;
          result_o.cmd_byte = rd_a_i;
          result_o.cmd_last = (crem_q == 8'd1);
        end else if (CW'(avail_q) >= CW'(rd_a_i) + CW'(1)) begin
          if (rd_a_i == 8'd0) begin
            rp_d    = rp_inc1;
            avail_d = avail_q - VW'(1);
            result_o.status   = pcrd_pkg::STAT_CMD_EMPTY;
            result_o.cmd_last = 1'b1;
          end else begin
            rp_d    = rp_inc2;
            avail_d = avail_q - VW'(2);
            crem_d  = rd_a_i - 8'd1;
            result_o.status   = pcrd_pkg::STAT_CMD_BYTE;
            result_o.cmd_byte = rd_b_i;
            result_o.cmd_last = (rd_a_i == 8'd1);
          end
        end
      end
    end
  end

  // Read addresses follow the next read pointer so the data is ready for the next item.
  assign rd_addr_a_o = rp_d;
  assign rd_addr_b_o = ring_inc(rp_d);

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= '0;
      wp_q    <= '0;
      avail_q <= '0;
      pos_q   <= '0;
      hdr_q   <= '0;
      len_q   <= '0;
      rej_q   <= 1'b0;
      crem_q  <= '0;
      defer_q <= 1'b0;
    end else begin
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      avail_q <= avail_d;
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      len_q   <= len_d;
      rej_q   <= rej_d;
      crem_q  <= crem_d;
      defer_q <= defer_d;
    end
  end

  // Read pointer plus fill level lands on the write pointer.
  assign chk_sum = CW'(rp_q) + CW'(avail_q);

  `PCRD_ASSERT(a_avail_bound, CW'(avail_q) <= CW'(RING_DEPTH), "ring fill above depth")
  `PCRD_ASSERT(a_ptr_consistent, ((chk_sum >= CW'(RING_DEPTH)) ?
    AW'(chk_sum - CW'(RING_DEPTH)) : AW'(chk_sum)) == wp_q, "ring pointers disagree")
  `PCRD_ASSERT(a_cmd_in_ring, CW'(crem_q) <= CW'(avail_q), "command tail not in ring")

endmodule

`default_nettype wire

// ===== rtl/packet_to_command_ring_deframer_unit.sv =====
// Top level of the packet to command ring deframer.
// The input channel takes one item per cycle when not stalled: a packet byte
// (func 0, with a last flag) or a request for the next command byte (func 1).
// Each item gives exactly one result item on the output channel: byte taken,
// packet committed or dropped on a packet's last byte, or a command byte, an
// empty command or nothing ready for a request. The enable register is written
// on its own valid/ready channel, which is always ready.
// An item is registered in the input register, its work is done on the way
// into the result register, which offers the result once the item steps, and
// one item per cycle is sustained when neither the output stalls nor a copy runs.
// A committed body is written into the ring as its bytes arrive; where the
// ring had no room for a byte at that time, the commit starts a copy from the
// packet buffer that writes one byte per cycle through the single ring write
// port, and input items wait while the copy is busy.
// A stalled result holds the result register and then the input register;
// the input stalls when both are full or a copy runs with the input full.
// Reset empties the ring, drops any partial packet and clears enable.
`default_nettype none
`include "assert_macros.svh"

module packet_to_command_ring_deframer_unit #(
  parameter int unsigned RING_DEPTH = 128,
  parameter int unsigned PACKET_MAX = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Item input.
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       func_i,
  input  wire logic [7:0] packet_byte_i,
  input  wire logic       packet_last_i,
  // Result output.
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [2:0] status_o,
  output logic      [7:0] command_byte_o,
  output logic            command_last_o,
  // Configuration.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       enable_i
);

  localparam int unsigned BodyMax = PACKET_MAX - pcrd_pkg::HdrBytes;
  localparam int unsigned BW      = (BodyMax > 1) ? $clog2(BodyMax) : 1;
  localparam int unsigned AW      = $clog2(RING_DEPTH);

  logic              enable_q;
  logic              in_vld_q;
  logic              in_func_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              out_vld_q;
  pcrd_pkg::result_t out_res_q;
  pcrd_pkg::result_t step_res;
  logic              step;
  logic              accept;
  logic              copy_busy;

  logic [AW-1:0]     rd_addr_a, rd_addr_b;
  logic [7:0]        rd_a, rd_b;
  logic              spec_we;
  logic [AW-1:0]     spec_addr;
  logic              body_we;
  logic [BW-1:0]     body_idx;
  logic              copy_start;
  logic [7:0]        copy_len;
  logic [AW-1:0]     copy_addr;
  logic              cp_we;
  logic [AW-1:0]     cp_addr;
  logic [7:0]        cp_data;
  logic              ring_we;
  logic [AW-1:0]     ring_addr;
  logic [7:0]        ring_data;

  // Handshake control.
  assign step        = in_vld_q && (!out_vld_q || !out_stall_i) && !copy_busy;
  assign in_stall_o  = in_vld_q && !step;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enable_q <= enable_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_func_q <= func_i;
      in_byte_q <= packet_byte_i;
      in_last_q <= packet_last_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_res_q.status;
  assign command_byte_o = out_res_q.cmd_byte;
  assign command_last_o = out_res_q.cmd_last;

  pcrd_core #(
    .RING_DEPTH(RING_DEPTH),
    .PACKET_MAX(PACKET_MAX)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .enable_i     (enable_q),
    .func_i       (in_func_q),
    .packet_byte_i(in_byte_q),
    .packet_last_i(in_last_q),
    .rd_a_i       (rd_a),
    .rd_b_i       (rd_b),
    .rd_addr_a_o  (rd_addr_a),
    .rd_addr_b_o  (rd_addr_b),
    .spec_we_o    (spec_we),
    .spec_addr_o  (spec_addr),
    .body_we_o    (body_we),
    .body_idx_o   (body_idx),
    .copy_start_o (copy_start),
    .copy_len_o   (copy_len),
    .copy_addr_o  (copy_addr),
    .result_o     (step_res)
  );

  pcrd_body_copy #(
    .RING_DEPTH(RING_DEPTH),
    .PACKET_MAX(PACKET_MAX)
  ) u_body_copy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .body_we_i   (body_we),
    .body_idx_i  (body_idx),
    .body_data_i (in_byte_q),
    .start_i     (copy_start),
    .start_len_i (copy_len),
    .start_addr_i(copy_addr),
    .busy_o      (copy_busy),
    .ring_we_o   (cp_we),
    .ring_addr_o (cp_addr),
    .ring_data_o (cp_data)
  );

  // Ring write port: the copy pass owns it while it runs.
  assign ring_we   = cp_we || spec_we;
  assign ring_addr = cp_we ? cp_addr : spec_addr;
  assign ring_data = cp_we ? cp_data : in_byte_q;

  pcrd_ring_mem #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring_mem (
    .clk_i    (clk_i),
    .we_i     (ring_we),
    .waddr_i  (ring_addr),
    .wdata_i  (ring_data),
    .raddr_a_i(rd_addr_a),
    .raddr_b_i(rd_addr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  `PCRD_ASSERT_IMP(a_no_step_in_copy, copy_busy, !step, "item stepped during copy pass")
  `PCRD_ASSERT_IMP(a_no_write_clash, cp_we, !spec_we, "two ring writes in one cycle")
  `PCRD_ASSERT_NXT(a_step_gives_result, step, out_vld_q, "stepped item left no result")

endmodule

`default_nettype wire
